@@ hdl/irpg_pkg.sv @@
// irpg_pkg: shared constants, codes and types for the IR pulse-gap capture block.
// Depends on nothing; imported by irpg_gap_unit and ir_pulse_gap_capture_core.
`timescale 1ns / 1ps

package irpg_pkg;

  // Store geometry
  localparam int CODE_SLOTS  = 128;
  localparam int CODE_LENGTH = 64;
  localparam int SLOT_W      = $clog2(CODE_SLOTS);
  localparam int POS_W       = $clog2(CODE_LENGTH);
  localparam int POS_CNT_W   = POS_W + 1;
  localparam int ADDR_W      = SLOT_W + POS_W;
  localparam int STORE_DEPTH = CODE_SLOTS * (1 << POS_W);

  // Register map
  localparam int  REG_CNT         = 2;
  localparam int  CFG_ADDR_W      = $clog2(REG_CNT) + 2;
  localparam logic REG_WATCHED_PIN = 1'b0;
  localparam logic REG_END_GAP     = 1'b1;
  localparam logic [31:0] END_GAP_RESET = 32'd30000;

  // Item codes
  localparam logic       OP_EVENT   = 1'b0;
  localparam logic       OP_READ    = 1'b1;
  localparam logic [1:0] LEVEL_FALL = 2'd0;
  localparam logic [1:0] LEVEL_RISE = 2'd1;
  localparam logic       KIND_NONE  = 1'b0;
  localparam logic       KIND_GAP   = 1'b1;

  // Gap unit result
  typedef struct packed {
    logic [31:0] sum;   // saturated running gap
    logic        over;  // sum beyond the end-of-code limit
  } gap_res_t;

  // One result word
  typedef struct packed {
    logic        kind;
    logic [31:0] gap_us;
    logic        last;
  } res_t;

endpackage

@@ hdl/irpg_gap_unit.sv @@
// irpg_gap_unit: saturating accumulation of a gap and compare against the end limit.
// Depends on irpg_pkg.
`timescale 1ns / 1ps

module irpg_gap_unit (
  input  logic [31:0]       running_gap,
  input  logic [31:0]       delta,
  input  logic [31:0]       limit,
  output irpg_pkg::gap_res_t res
);
  import irpg_pkg::*;

  logic [32:0] raw_sum;

  // Add with carry, clamp on overflow
  assign raw_sum  = {1'b0, running_gap} + {1'b0, delta};
  assign res.sum  = raw_sum[32] ? 32'hFFFF_FFFF : raw_sum[31:0];
  assign res.over = res.sum > limit;

endmodule

@@ hdl/ir_pulse_gap_capture_core.sv @@
// ir_pulse_gap_capture_core: top level of the IR pulse-gap capture block.
// Depends on irpg_pkg and irpg_gap_unit; holds the code store memory.
//
//   channel | ports                                | transfer when
//   --------+--------------------------------------+-------------------------------------
//   in      | in_valid in_stall in_op in_pin       | in_valid & !in_stall
//           | in_level in_tick_us                  |
//   out     | out_valid out_stall out_kind         | out_valid & !out_stall
//           | out_gap_us out_last                  |
//   cfg     | psel penable pwrite paddr pwdata     | psel & penable & pwrite & pready
//           | prdata pready                        |
//
// A pin event is accepted (tick difference registered), then the gap
// add/compare and at most one store write follow. A read returns its words from
// the single read port of the code store, which gives one word a cycle while the
// two-entry output queue has room; the queue absorbs out_stall. One item is
// handled at a time. Reset is synchronous; no clearing pass runs.
`timescale 1ns / 1ps

module ir_pulse_gap_capture_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [4:0]                         in_pin,
  input  logic [1:0]                         in_level,
  input  logic [31:0]                        in_tick_us,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_kind,
  output logic [31:0]                        out_gap_us,
  output logic                               out_last,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [irpg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import irpg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVENT = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  // Configuration registers
  logic [4:0]  watched_pin_r;
  logic [31:0] end_gap_limit_r;
  logic        cfg_wr;
  logic        cfg_sel;

  // Control state
  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] write_slot_r, read_slot_r;
  logic [POS_W-1:0]  entry_pos_r;
  logic              capturing_r;
  logic              prev_level_r;
  logic [31:0]       prev_tick_r;
  logic [31:0]       running_gap_r;

  // Registered event
  logic              ev_match_r;
  logic [1:0]        ev_level_r;
  logic [31:0]       ev_tick_r;
  logic [31:0]       delta_r;
  logic              ev_edge;
  gap_res_t          gap;

  // Read sequencing
  logic                 rd_empty_r;
  logic [POS_CNT_W-1:0] rd_pos_r;
  logic [POS_W-1:0]     resp_pos_r;
  logic                 rvalid_r;
  logic [31:0]          rdata_r;
  logic                 final_now;
  logic                 issue;
  logic                 room;
  logic [2:0]           occ;

  // Code store
  logic [31:0]       store_mem [STORE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Output queue
  res_t       fifo_q [2];
  logic       fifo_wp_r, fifo_rp_r;
  logic [1:0] fifo_cnt_r;
  logic       push, pop;
  res_t       push_data;

  logic in_acc;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1:2] == REG_END_GAP;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = cfg_sel ? end_gap_limit_r : {27'd0, watched_pin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_pin_r   <= '0;
      end_gap_limit_r <= END_GAP_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel) end_gap_limit_r <= pwdata;
      else         watched_pin_r   <= pwdata[4:0];
    end
  end

  // ---------------- input handshake ----------------
  assign in_stall = state_r != ST_IDLE;
  assign in_acc   = in_valid & ~in_stall;

  // Event capture: tick difference taken at accept, wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_match_r <= in_pin == watched_pin_r;
      ev_level_r <= in_level;
      ev_tick_r  <= in_tick_us;
      delta_r    <= in_tick_us - prev_tick_r;
    end
  end

  irpg_gap_unit u_gap (
    .running_gap (running_gap_r),
    .delta       (delta_r),
    .limit       (end_gap_limit_r),
    .res         (gap)
  );

  always_comb begin
    ev_edge = ev_level_r inside {LEVEL_FALL, LEVEL_RISE};
  end

  // ---------------- capture state update ----------------
  // Opening an entry writes nothing to the store: every entry of a completed
  // code is written with its gap or the terminator before it is read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {write_slot_r, entry_pos_r};
    mem_wdata = gap.over ? 32'd0 : gap.sum;
    if (state_r == ST_EVENT && ev_match_r && capturing_r) mem_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r  <= '0;
      entry_pos_r   <= '0;
      capturing_r   <= 1'b0;
      prev_level_r  <= 1'b0;
      prev_tick_r   <= '0;
      running_gap_r <= '0;
    end else if (state_r == ST_EVENT && ev_match_r) begin
      if (!capturing_r) begin
        // first real edge starts a code
        if (ev_edge) begin
          capturing_r   <= 1'b1;
          entry_pos_r   <= '0;
          running_gap_r <= '0;
          prev_level_r  <= ev_level_r[0];
          prev_tick_r   <= ev_tick_r;
        end
      end else begin
        prev_tick_r   <= ev_tick_r;
        running_gap_r <= gap.sum;
        if (gap.over) begin
          // terminator written, ring advances
          capturing_r  <= 1'b0;
          write_slot_r <= (write_slot_r == SLOT_W'(CODE_SLOTS - 1)) ? '0
                                                                   : write_slot_r + 1'b1;
        end else if (ev_edge && ev_level_r[0] != prev_level_r) begin
          prev_level_r <= ev_level_r[0];
          if (entry_pos_r == POS_W'(CODE_LENGTH - 1)) begin
            capturing_r <= 1'b0;  // too long: code dropped, slot reused
          end else begin
            entry_pos_r   <= entry_pos_r + 1'b1;
            running_gap_r <= '0;
          end
        end
      end
    end
  end

  // ---------------- code store ----------------
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
  end

  assign mem_raddr = {read_slot_r, rd_pos_r[POS_W-1:0]};

  always_ff @(posedge clk) begin
    if (issue) rdata_r <= store_mem[mem_raddr];
  end

  // ---------------- read streaming ----------------
  assign pop       = out_valid & ~out_stall;
  assign occ       = 3'(fifo_cnt_r) + 3'(rvalid_r) - 3'(pop);
  assign room      = occ < 3'd2;
  assign final_now = rvalid_r & ((rdata_r == 32'd0) ||
                                 (resp_pos_r == POS_W'(CODE_LENGTH - 1)));
  assign issue     = (state_r == ST_READ) & ~rd_empty_r & room & ~final_now &
                     (rd_pos_r < POS_CNT_W'(CODE_LENGTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r    <= 1'b0;
      read_slot_r <= '0;
      rd_empty_r  <= 1'b0;
      rd_pos_r    <= '0;
      resp_pos_r  <= '0;
    end else begin
      rvalid_r <= issue;
      if (in_acc && in_op == OP_READ) begin
        rd_empty_r <= read_slot_r == write_slot_r;
        rd_pos_r   <= '0;
        resp_pos_r <= '0;
      end
      if (issue)    rd_pos_r   <= rd_pos_r + 1'b1;
      if (rvalid_r) resp_pos_r <= resp_pos_r + 1'b1;
      if (final_now) begin
        read_slot_r <= (read_slot_r == SLOT_W'(CODE_SLOTS - 1)) ? '0
                                                               : read_slot_r + 1'b1;
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_op == OP_READ) ? ST_READ : ST_EVENT;
      end
      ST_EVENT: state_nxt = ST_IDLE;
      ST_READ: begin
        if (final_now || (rd_empty_r && room)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- output queue ----------------
  always_comb begin
    push             = rvalid_r | ((state_r == ST_READ) & rd_empty_r & room);
    push_data.kind   = rvalid_r ? KIND_GAP : KIND_NONE;
    push_data.gap_us = rvalid_r ? rdata_r : 32'd0;
    push_data.last   = rvalid_r ? final_now : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) fifo_q[fifo_wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= 1'b0;
      fifo_rp_r  <= 1'b0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) fifo_wp_r <= ~fifo_wp_r;
      if (pop)  fifo_rp_r <= ~fifo_rp_r;
      fifo_cnt_r <= 2'(3'(fifo_cnt_r) + 3'(push) - 3'(pop));
    end
  end

  assign out_valid  = fifo_cnt_r != 2'd0;
  assign out_kind   = fifo_q[fifo_rp_r].kind;
  assign out_gap_us = fifo_q[fifo_rp_r].gap_us;
  assign out_last   = fifo_q[fifo_rp_r].last;

`ifndef SYNTHESIS
  // queue never written while full and not draining
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_cnt_r == 2'd2 && !pop))
    else $error("output queue overflow");

  // store data only returns for reads issued by the read sequencer
  a_rvalid_src: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> $past(state_r) == ST_READ)
    else $error("store read outside a read request");

  // an event update always returns straight to idle
  a_event_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVENT |=> state_r == ST_IDLE)
    else $error("event update did not finish");

  // no store read beyond the code length or during a store write
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> rd_pos_r < POS_CNT_W'(CODE_LENGTH) && !mem_we)
    else $error("store read out of range or during a write");
`endif

endmodule

@@ verif/ir_pulse_gap_capture_core_tb.sv @@
// ir_pulse_gap_capture_core_tb: self-checking bench for the IR pulse-gap capture core.
// Depends on irpg_pkg and the core RTL; a built-in capture predictor checks every
// result word, with directed rows first and constrained-by-hand random traffic after.
`timescale 1ns / 1ps

module ir_pulse_gap_capture_core_tb;
  import irpg_pkg::*;

  localparam logic [1:0] LEVEL_TIMEOUT   = 2'd2;
  localparam logic [1:0] LEVEL_SPARE     = 2'd3;   // behaves as a timeout
  localparam int         WATCHDOG_CYCLES = 4000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 10;

  // Directed stimulus row; want is only used where pinned is set
  typedef struct packed {
    logic       op;
    logic [4:0] pin;
    logic [1:0] level;
    logic [31:0] tick;
    logic       pinned;
    res_t       want;
  } step_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam step_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{OP_READ,  5'd0,  LEVEL_FALL,    32'd0,          1'b1, '{KIND_NONE, 32'd0, 1'b1}},
    '{OP_EVENT, 5'd0,  LEVEL_TIMEOUT, 32'd100,        1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd5,  LEVEL_FALL,    32'd200,        1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_FALL,    32'hFFFF_FF00,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_FALL,    32'hFFFF_FF80,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_RISE,    32'h0000_0100,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_SPARE,   32'h0000_0200,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_FALL,    32'h0000_0300,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_RISE,    32'h0000_0300,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_FALL,    32'h0000_0400,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_TIMEOUT, 32'd31024,      1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_TIMEOUT, 32'd31025,      1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_READ,  5'd31, LEVEL_SPARE,   32'hFFFF_FFFF,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_READ,  5'd0,  LEVEL_FALL,    32'd0,          1'b1, '{KIND_NONE, 32'd0, 1'b1}},
    '{OP_EVENT, 5'd31, LEVEL_RISE,    32'hFFFF_FFFF,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_RISE,    32'd0,          1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_EVENT, 5'd0,  LEVEL_FALL,    32'hFFFF_FFFF,  1'b0, '{KIND_NONE, 32'd0, 1'b0}},
    '{OP_READ,  5'd0,  LEVEL_FALL,    32'd0,          1'b1, '{KIND_GAP,  32'd0, 1'b1}},
    '{OP_READ,  5'd0,  LEVEL_FALL,    32'd0,          1'b1, '{KIND_NONE, 32'd0, 1'b1}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [4:0]            in_pin;
  logic [1:0]            in_level;
  logic [31:0]           in_tick_us;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_kind;
  logic [31:0]           out_gap_us;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ir_pulse_gap_capture_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_pin     (in_pin),
    .in_level   (in_level),
    .in_tick_us (in_tick_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_gap_us (out_gap_us),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Capture predictor state and its register copies
  logic [31:0]       code_mem_model [STORE_DEPTH];
  logic [SLOT_W-1:0] m_wslot    = '0;
  logic [SLOT_W-1:0] m_rslot    = '0;
  logic [POS_W-1:0]  m_pos      = '0;
  bit                m_capt     = 1'b0;
  logic              m_prev_lvl = 1'b0;
  logic [31:0]       m_prev_tick = '0;
  logic [31:0]       m_run      = '0;
  logic [4:0]        m_pin      = '0;
  logic [31:0]       m_limit    = END_GAP_RESET;

  res_t gap_words_due [$];
  bit   typed_on = 1'b0;
  res_t typed_word;
  bit   hold_off_req = 1'b0;
  logic [31:0] tick_now = '0;

  int errors        = 0;
  int items_sent    = 0;
  int reads_sent    = 0;
  int counted_items = 0;
  int words_seen    = 0;
  int codes_closed  = 0;
  int idle_cycles   = 0;

  // Expected result words for one accepted transfer on the input channel
  task automatic predict_item(input logic op, input logic [4:0] pin, input logic [1:0] level,
                              input logic [31:0] tick);
    int          base;
    logic [31:0] delta;
    logic [31:0] word;
    logic [32:0] sum;
    bit          is_edge;
    bit          fin;
    if (op == OP_READ) begin
      if (m_rslot == m_wslot) begin
        gap_words_due.push_back(res_t'{KIND_NONE, 32'd0, 1'b1});
        return;
      end
      base = int'(m_rslot) * CODE_LENGTH;
      for (int n = 0; n < CODE_LENGTH; n++) begin
        word = code_mem_model[base + n];
        fin  = (word == 32'd0) || (n == CODE_LENGTH - 1);
        gap_words_due.push_back(res_t'{KIND_GAP, word, fin});
        if (fin) break;
      end
      m_rslot = m_rslot + 1'b1;
      return;
    end
    if (pin != m_pin) return;
    base    = int'(m_wslot) * CODE_LENGTH;
    is_edge = (level == LEVEL_FALL) || (level == LEVEL_RISE);
    // idle: only a real edge opens a code
    if (!m_capt) begin
      if (!is_edge) return;
      m_pos       = '0;
      m_run       = '0;
      code_mem_model[base] = 32'd0;
      m_capt      = 1'b1;
      m_prev_lvl  = level[0];
      m_prev_tick = tick;
      return;
    end
    // modular tick difference, saturating accumulation
    delta       = tick - m_prev_tick;
    m_prev_tick = tick;
    sum         = {1'b0, m_run} + {1'b0, delta};
    m_run       = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (m_run > m_limit) begin
      code_mem_model[base + int'(m_pos)] = 32'd0;
      m_capt  = 1'b0;
      m_wslot = m_wslot + 1'b1;
      codes_closed++;
      return;
    end
    code_mem_model[base + int'(m_pos)] = m_run;
    if (!is_edge || level[0] == m_prev_lvl) return;
    m_prev_lvl = level[0];
    // length limit: code dropped, slot reused
    if (int'(m_pos) == CODE_LENGTH - 1) begin
      m_capt = 1'b0;
      return;
    end
    m_pos = m_pos + 1'b1;
    m_run = '0;
    code_mem_model[base + int'(m_pos)] = 32'd0;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transfer monitor, result checker and watchdog
  always @(posedge clk) begin : monitor
    int   depth;
    res_t got;
    res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        depth = gap_words_due.size();
        predict_item(in_op, in_pin, in_level, in_tick_us);
        if (typed_on) begin
          while (gap_words_due.size() > depth) void'(gap_words_due.pop_back());
          gap_words_due.push_back(typed_word);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_gap_us, out_last};
        words_seen++;
        if (gap_words_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d gap %0d last %0d",
                   $time, got.kind, got.gap_us, got.last);
          errors++;
        end else begin
          want = gap_words_due.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
            errors++;
          end
          if (got.gap_us !== want.gap_us) begin
            $display("%0t: gap_us expected %0d got %0d", $time, want.gap_us, got.gap_us);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[ir_pulse_gap_capture_core] ERROR");
        $finish;
      end
    end
  end

  // Result sink: random stall stretches, plus one long hold-off on request
  initial begin : result_sink
    int r;
    int span;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall = 1'b0;
        span = $urandom_range(1, 20);
      end else if (r < 92) begin
        out_stall = 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        out_stall = 1'b1;
        span = $urandom_range(10, 40);
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  // One input transfer, then at times a random gap; returns on a falling edge
  task automatic send_item(input logic op, input logic [4:0] pin, input logic [1:0] level,
                           input logic [31:0] tick);
    int r;
    in_op      = op;
    in_pin     = pin;
    in_level   = level;
    in_tick_us = tick;
    in_valid   = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_READ) reads_sent++;
    if (op == OP_READ || pin == m_pin) counted_items++;
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (r >= 55) begin
      in_valid = 1'b0;
      repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(negedge clk);
    end
  endtask

  task automatic send_read();
    send_item(OP_READ, 5'($urandom), 2'($urandom), $urandom);
  endtask

  // Event on the watched pin, step us after the last one; sometimes a read slips in
  task automatic code_event(input logic [1:0] level, input logic [31:0] step);
    tick_now = tick_now + step;
    send_item(OP_EVENT, m_pin, level, tick_now);
    if ($urandom_range(0, 99) < 8) send_read();
  endtask

  // Well-formed code: opening edge, level changes with filler events, closing gap
  task automatic send_code(input int changes);
    logic        lvl;
    logic [31:0] step_max;
    logic [31:0] close_gap;
    int          r;
    step_max = m_limit >> 3;
    lvl      = 1'($urandom);
    if ($urandom_range(0, 9) == 0) tick_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
    code_event({1'b0, lvl}, 32'($urandom_range(0, 100000)));
    for (int c = 0; c < changes; c++) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
        r = $urandom_range(0, 2);
        code_event(r == 0 ? LEVEL_TIMEOUT : (r == 1 ? LEVEL_SPARE : {1'b0, lvl}),
                   32'($urandom_range(0, step_max)));
      end
      lvl = ~lvl;
      code_event({1'b0, lvl}, 32'($urandom_range(0, step_max)));
    end
    if (m_limit > 32'hFFFF_0000) close_gap = $urandom;
    else close_gap = m_limit + 32'd1 + 32'($urandom_range(0, 5000));
    code_event(LEVEL_TIMEOUT, close_gap);
  endtask

  // Random mix until target transfers that the block acts on
  task automatic run_random(input int target);
    int r;
    logic [31:0] tick;
    counted_items = 0;
    while (counted_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_code($urandom_range(0, 99) < 6 ? $urandom_range(60, 68) : $urandom_range(0, 9));
      end else if (r < 75) begin
        send_read();
      end else begin
        tick = $urandom_range(0, 1) ? tick_now + 32'($urandom_range(0, 2000)) : $urandom;
        send_item(OP_EVENT, $urandom_range(0, 1) ? m_pin : 5'($urandom), 2'($urandom), tick);
        tick_now = tick;
      end
    end
  endtask

  // Register write (optional) followed by a read-back check
  task automatic cfg_access(input logic idx, input bit do_write, input logic [31:0] value);
    logic [31:0] want;
    if (do_write) begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (idx == REG_WATCHED_PIN) m_pin = value[4:0];
      else m_limit = value;
      @(negedge clk);
    end
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_WATCHED_PIN) ? {27'd0, m_pin} : m_limit;
    if (prdata !== want) begin
      $display("%0t: register %0d expected %0d got %0d", $time, idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Stop offering, let every result drain and the last event settle
  task automatic drain_block();
    in_valid = 1'b0;
    while (gap_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_EVENT;
    in_pin     = '0;
    in_level   = LEVEL_FALL;
    in_tick_us = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset values, then the directed rows
    cfg_access(REG_WATCHED_PIN, 1'b0, 32'd0);
    cfg_access(REG_END_GAP, 1'b0, 32'd0);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_on   = DIRECTED[i].pinned;
      typed_word = DIRECTED[i].want;
      send_item(DIRECTED[i].op, DIRECTED[i].pin, DIRECTED[i].level, DIRECTED[i].tick);
    end
    typed_on = 1'b0;
    drain_block();

    // top pin, mid limit
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd31);
    cfg_access(REG_END_GAP, 1'b1, 32'd20000);
    run_random(12);
    drain_block();

    // zero limit: any non-zero gap ends a code
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd0);
    cfg_access(REG_END_GAP, 1'b1, 32'd0);
    run_random(8);
    drain_block();

    // largest limit: codes never end, gaps saturate
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd17);
    cfg_access(REG_END_GAP, 1'b1, 32'hFFFF_FFFF);
    run_random(8);
    drain_block();

    // sender pauses mid-phase until every result is back
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd9);
    cfg_access(REG_END_GAP, 1'b1, 32'd5000);
    run_random(6);
    drain_block();
    run_random(6);
    drain_block();

    // ring overflow: more codes than slots with no read in between
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd3);
    cfg_access(REG_END_GAP, 1'b1, 32'd1000);
    for (int i = 0; i < CODE_SLOTS + 1; i++) begin
      send_item(OP_EVENT, m_pin, LEVEL_FALL, tick_now);
      tick_now = tick_now + 32'd1001 + 32'(i);
      send_item(OP_EVENT, m_pin, LEVEL_TIMEOUT, tick_now);
    end
    repeat (3) send_read();
    drain_block();

    // long receiver hold-off while reads keep coming
    cfg_access(REG_WATCHED_PIN, 1'b1, 32'd12);
    cfg_access(REG_END_GAP, 1'b1, 32'd30000);
    repeat (2) send_code($urandom_range(1, 6));
    hold_off_req = 1'b1;
    repeat (10) send_read();
    run_random(8);
    drain_block();

    if (gap_words_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, gap_words_due.size());
      errors++;
    end
    $display("Covered %0d transfers in (%0d reads), %0d result words, %0d codes closed,",
             items_sent, reads_sent, words_seen, codes_closed);
    $display("zero and full-scale end limits, pin 0 to 31, ring overflow and hold-off.");
    if (errors == 0) begin
      $display("[ir_pulse_gap_capture_core] OK");
    end else begin
      $display("[ir_pulse_gap_capture_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/irpg_pkg.sv
hdl/irpg_gap_unit.sv
hdl/ir_pulse_gap_capture_core.sv
verif/ir_pulse_gap_capture_core_tb.sv
